// File: rtl/core/beat_strobe_pixel_color_macros.svh
// Assertion macros used by the core RTL.
`ifndef BEAT_STROBE_PIXEL_COLOR_MACROS_SVH
`define BEAT_STROBE_PIXEL_COLOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BSPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define BSPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bspc_pkg.sv
package bspc_pkg;

    localparam int MAX_LEDS = 1024;
    localparam int ADDR_W   = 5;

    localparam logic [2:0] REG_TEMPO        = 3'd0;
    localparam logic [2:0] REG_SPAN         = 3'd1;
    localparam logic [2:0] REG_STROBE_LEVEL = 3'd2;
    localparam logic [2:0] REG_SUSTAIN      = 3'd3;
    localparam logic [2:0] REG_TRADE_SIDES  = 3'd4;
    localparam logic [2:0] REG_CENTER_LED   = 3'd5;
    localparam logic [2:0] REG_STRIP_LENGTH = 3'd6;

    localparam int TEMPO_RST        = 118;
    localparam int SPAN_RST         = 49;
    localparam int STROBE_LEVEL_RST = 170;
    localparam int SUSTAIN_RST      = 110;
    localparam int TRADE_SIDES_RST  = 1;
    localparam int CENTER_LED_RST   = 0;
    localparam int STRIP_LENGTH_RST = 1024;

    localparam int MS_PER_MINUTE = 60000;
    localparam int BPM_MIN       = 60;
    localparam int HIT_MS_MIN    = 60;
    localparam int FLASH_MS      = 70;
    localparam int DIM_GAIN      = 70;

    localparam int BPM_RST     = BPM_MIN + (TEMPO_RST * 130) / 255;
    localparam int BEAT_MS_RST = MS_PER_MINUTE / BPM_RST;
    localparam int HIT_MS_RST  = HIT_MS_MIN + (SUSTAIN_RST * (BEAT_MS_RST - HIT_MS_MIN)) / 255;
    localparam int HALF_RST    = 1 + (SPAN_RST * 126) / 255;

    localparam logic [23:0] COLOR_RED   = 24'hFF0000;
    localparam logic [23:0] COLOR_PINK  = 24'hFF005A;
    localparam logic [23:0] COLOR_AMBER = 24'hFF7800;
    localparam logic [23:0] COLOR_BLUE  = 24'h0078FF;

    function automatic logic [7:0] sc8(input logic [7:0] a, input logic [7:0] b);
        logic [16:0] p;
        p = 17'(a) * 17'({1'b0, b} + 9'd1);
        return p[15:8];
    endfunction

    function automatic logic [23:0] palette(input logic [1:0] idx);
        logic [23:0] c;
        case (idx)
            2'd0:    c = COLOR_RED;
            2'd1:    c = COLOR_PINK;
            2'd2:    c = COLOR_AMBER;
            2'd3:    c = COLOR_BLUE;
            default: c = COLOR_RED;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/beat_strobe_pixel_color.sv
// Pixel requests enter on start while busy is low, one per clock, and each gives exactly one
// result on done at the end of the pipeline; the receiver cannot stall, so results must be taken
// as they appear. The pipeline is the 32-step time/beat-length divider, one setup stage,
// 8-step hit and falloff dividers and four scaling stages. After a register write busy stays
// high, restarting from any later write, while an 18-step bit-serial divider
// derives the beat length and a reciprocal multiply derives the hit length.
`include "beat_strobe_pixel_color_macros.svh"

module beat_strobe_pixel_color (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bspc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic [31:0]                time_ms,
    input  logic signed [7:0]          offset,
    output logic                       done,
    output logic                       in_span,
    output logic [9:0]                 led_index,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue
);

    localparam int DIV_STEPS  = 32;
    localparam int MOD_STEPS  = 11;
    localparam int QDIV_STEPS = 8;
    localparam int LATENCY    = DIV_STEPS + QDIV_STEPS + 5;
    localparam int SEQ_STEPS  = 18;
    localparam int HIT_RECIP  = 263173;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_BEAT,
        S_BEAT,
        S_LOAD_HIT,
        S_HIT
    } seq_state_t;

    typedef struct packed {
        logic               valid;
        logic [31:0]        num;
        logic [9:0]         rem;
        logic [1:0]         q;
        logic signed [7:0]  offset;
        logic               xneg;
        logic [10:0]        mnum;
        logic [10:0]        mrem;
    } d1_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  n1lo;
        logic [9:0]  r1;
        logic [7:0]  q1;
        logic [7:0]  n2lo;
        logic [6:0]  r2;
        logic [7:0]  q2;
        logic        hit_on;
        logic        strobe_on;
        logic [7:0]  sval;
        logic        in_range;
        logic        dim;
        logic [1:0]  beat;
        logic [9:0]  led;
    } mid_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  hit;
        logic [7:0]  falloff;
        logic [7:0]  strobe;
        logic        in_range;
        logic        dim;
        logic [1:0]  beat;
        logic [9:0]  led;
    } p2_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  lit;
        logic [7:0]  white;
        logic        strobe_nz;
        logic        in_range;
        logic        dim;
        logic [1:0]  beat;
        logic [9:0]  led;
    } p3_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  level;
        logic [7:0]  white;
        logic        strobe_nz;
        logic        in_range;
        logic [1:0]  beat;
        logic [9:0]  led;
    } p4_t;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    logic [7:0]  tempo_reg;
    logic [7:0]  span_reg;
    logic [7:0]  strobe_level_reg;
    logic [7:0]  sustain_reg;
    logic        trade_sides_reg;
    logic [9:0]  center_led_reg;
    logic [10:0] strip_length_reg;

    logic [9:0]  beat_ms_reg;
    logic [9:0]  hit_ms_reg;
    logic [6:0]  half_span_reg;

    seq_state_t  seq_state_reg;
    logic [17:0] dv_num_reg;
    logic [7:0]  dv_rem_reg;
    logic [17:0] dv_q_reg;
    logic [7:0]  dv_den_reg;
    logic [4:0]  dv_cnt_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [8:0]  dv_t;
    logic        dv_ge;
    logic [7:0]  dv_rem_next;
    logic [17:0] dv_q_next;
    logic [36:0] hit_prod;
    logic [7:0]  bpm;
    logic [7:0]  half_calc;
    logic [10:0] len_eff;
    logic        accept;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign busy    = (seq_state_reg != S_IDLE);
    assign accept  = start && !busy;

    always_comb
    begin
        case (cfg_idx)
            bspc_pkg::REG_TEMPO:        prdata = {24'd0, tempo_reg};
            bspc_pkg::REG_SPAN:         prdata = {24'd0, span_reg};
            bspc_pkg::REG_STROBE_LEVEL: prdata = {24'd0, strobe_level_reg};
            bspc_pkg::REG_SUSTAIN:      prdata = {24'd0, sustain_reg};
            bspc_pkg::REG_TRADE_SIDES:  prdata = {31'd0, trade_sides_reg};
            bspc_pkg::REG_CENTER_LED:   prdata = {22'd0, center_led_reg};
            bspc_pkg::REG_STRIP_LENGTH: prdata = {21'd0, strip_length_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg        <= 8'(bspc_pkg::TEMPO_RST);
            span_reg         <= 8'(bspc_pkg::SPAN_RST);
            strobe_level_reg <= 8'(bspc_pkg::STROBE_LEVEL_RST);
            sustain_reg      <= 8'(bspc_pkg::SUSTAIN_RST);
            trade_sides_reg  <= 1'(bspc_pkg::TRADE_SIDES_RST);
            center_led_reg   <= 10'(bspc_pkg::CENTER_LED_RST);
            strip_length_reg <= 11'(bspc_pkg::STRIP_LENGTH_RST);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                bspc_pkg::REG_TEMPO:        tempo_reg        <= pwdata[7:0];
                bspc_pkg::REG_SPAN:         span_reg         <= pwdata[7:0];
                bspc_pkg::REG_STROBE_LEVEL: strobe_level_reg <= pwdata[7:0];
                bspc_pkg::REG_SUSTAIN:      sustain_reg      <= pwdata[7:0];
                bspc_pkg::REG_TRADE_SIDES:  trade_sides_reg  <= pwdata[0];
                bspc_pkg::REG_CENTER_LED:   center_led_reg   <= pwdata[9:0];
                bspc_pkg::REG_STRIP_LENGTH: strip_length_reg <= pwdata[10:0];
                default:                    ;
            endcase
        end
    end

    // Derived timing: restoring divider for the beat length, reciprocal multiply for the hit.
    assign bpm       = 8'(bspc_pkg::BPM_MIN) + div255(16'(tempo_reg) * 16'd130);
    assign half_calc = 8'd1 + div255(16'(span_reg) * 16'd126);
    assign dv_t        = {dv_rem_reg, dv_num_reg[17]};
    assign dv_ge       = (dv_t >= {1'b0, dv_den_reg});
    assign dv_rem_next = dv_ge ? 8'(dv_t - {1'b0, dv_den_reg}) : dv_t[7:0];
    assign dv_q_next   = {dv_q_reg[16:0], dv_ge};
    assign hit_prod    = 37'(dv_num_reg) * 37'(HIT_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= S_IDLE;
            beat_ms_reg   <= 10'(bspc_pkg::BEAT_MS_RST);
            hit_ms_reg    <= 10'(bspc_pkg::HIT_MS_RST);
            half_span_reg <= 7'(bspc_pkg::HALF_RST);
            dv_num_reg    <= '0;
            dv_rem_reg    <= '0;
            dv_q_reg      <= '0;
            dv_den_reg    <= '0;
            dv_cnt_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            seq_state_reg <= S_LOAD_BEAT;
        end
        else
        begin
            case (seq_state_reg)
                S_IDLE:
                begin
                    seq_state_reg <= S_IDLE;
                end
                S_LOAD_BEAT:
                begin
                    half_span_reg <= half_calc[6:0];
                    dv_num_reg    <= 18'(bspc_pkg::MS_PER_MINUTE);
                    dv_den_reg    <= bpm;
                    dv_rem_reg    <= '0;
                    dv_q_reg      <= '0;
                    dv_cnt_reg    <= 5'(SEQ_STEPS - 1);
                    seq_state_reg <= S_BEAT;
                end
                S_BEAT:
                begin
                    dv_num_reg <= {dv_num_reg[16:0], 1'b0};
                    dv_rem_reg <= dv_rem_next;
                    dv_q_reg   <= dv_q_next;
                    dv_cnt_reg <= dv_cnt_reg - 5'd1;
                    if (dv_cnt_reg == 5'd0)
                    begin
                        beat_ms_reg   <= dv_q_next[9:0];
                        seq_state_reg <= S_LOAD_HIT;
                    end
                end
                S_LOAD_HIT:
                begin
                    dv_num_reg    <= 18'(sustain_reg) *
                                     18'(beat_ms_reg - 10'(bspc_pkg::HIT_MS_MIN));
                    seq_state_reg <= S_HIT;
                end
                S_HIT:
                begin
                    hit_ms_reg    <= 10'(bspc_pkg::HIT_MS_MIN) + hit_prod[35:26];
                    seq_state_reg <= S_IDLE;
                end
                default:
                begin
                    seq_state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (strip_length_reg == 11'd0)
        begin
            len_eff = 11'd1;
        end
        else if (32'(strip_length_reg) > 32'(bspc_pkg::MAX_LEDS))
        begin
            len_eff = 11'(bspc_pkg::MAX_LEDS);
        end
        else
        begin
            len_eff = strip_length_reg;
        end
    end

    // Beat divider: time / beat length, with the LED index modulo in the first stages.
    d1_t d1_init;
    d1_t d1_reg [DIV_STEPS];

    always_comb
    begin
        logic signed [11:0] x;
        x = $signed({2'b00, center_led_reg}) + 12'(offset);
        d1_init.valid  = accept;
        d1_init.num    = time_ms;
        d1_init.rem    = '0;
        d1_init.q      = '0;
        d1_init.offset = offset;
        d1_init.xneg   = x[11];
        d1_init.mnum   = x[11] ? 11'(-x) : x[10:0];
        d1_init.mrem   = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_d1
        d1_t cur;
        d1_t nx;

        if (k == 0)
        begin : g_first
            assign cur = d1_init;
        end
        else
        begin : g_rest
            assign cur = d1_reg[k-1];
        end

        always_comb
        begin
            logic [10:0] t;
            logic        ge;
            logic [11:0] mt;
            logic        mge;
            nx     = cur;
            t      = {cur.rem, cur.num[31]};
            ge     = (t >= {1'b0, beat_ms_reg});
            nx.rem = ge ? 10'(t - {1'b0, beat_ms_reg}) : t[9:0];
            nx.q   = {cur.q[0], ge};
            nx.num = {cur.num[30:0], 1'b0};
            mt     = {cur.mrem, cur.mnum[10]};
            mge    = (mt >= {1'b0, len_eff});
            if (k < MOD_STEPS)
            begin
                nx.mrem = mge ? 11'(mt - {1'b0, len_eff}) : mt[10:0];
                nx.mnum = {cur.mnum[9:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d1_reg[k] <= '0;
            end
            else
            begin
                d1_reg[k] <= nx;
            end
        end
    end

    // Set up hit and falloff divisions, strobe ramp and LED index.
    mid_t p1_next;
    mid_t p1_reg;

    always_comb
    begin
        d1_t         s;
        logic [9:0]  into;
        logic [17:0] n1;
        logic [24:0] sp;
        logic [7:0]  mag;
        logic [15:0] n2;
        logic [10:0] pos;
        s    = d1_reg[DIV_STEPS-1];
        into = s.rem;
        n1   = {into, 8'd0} - 18'(into);
        sp   = 25'(into[6:0]) * 25'd238782;
        mag  = s.offset[7] ? 8'(-s.offset) : 8'(s.offset);
        n2   = {mag, 8'd0} - 16'(mag);
        pos  = (s.xneg && s.mrem != 11'd0) ? 11'(len_eff - s.mrem) : s.mrem;

        p1_next.valid     = s.valid;
        p1_next.n1lo      = n1[7:0];
        p1_next.r1        = n1[17:8];
        p1_next.q1        = '0;
        p1_next.n2lo      = n2[7:0];
        p1_next.r2        = n2[14:8];
        p1_next.q2        = '0;
        p1_next.hit_on    = (into < hit_ms_reg);
        p1_next.strobe_on = (s.q == 2'd0) && (into < 10'(bspc_pkg::FLASH_MS));
        p1_next.sval      = 8'd255 - sp[23:16];
        p1_next.in_range  = ({1'b0, mag} <= {2'b00, half_span_reg});
        p1_next.dim       = trade_sides_reg && ((!s.offset[7]) != s.q[0]);
        p1_next.beat      = s.q;
        p1_next.led       = pos[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
        end
        else
        begin
            p1_reg <= p1_next;
        end
    end

    // Hit and falloff quotients, one bit per stage each.
    mid_t d2_reg [QDIV_STEPS];

    for (genvar k = 0; k < QDIV_STEPS; k++)
    begin : g_d2
        mid_t cur;
        mid_t nx;

        if (k == 0)
        begin : g_first
            assign cur = p1_reg;
        end
        else
        begin : g_rest
            assign cur = d2_reg[k-1];
        end

        always_comb
        begin
            logic [10:0] t1;
            logic        ge1;
            logic [7:0]  t2;
            logic        ge2;
            nx      = cur;
            t1      = {cur.r1, cur.n1lo[7]};
            ge1     = (t1 >= {1'b0, hit_ms_reg});
            nx.r1   = ge1 ? 10'(t1 - {1'b0, hit_ms_reg}) : t1[9:0];
            nx.q1   = {cur.q1[6:0], ge1};
            nx.n1lo = {cur.n1lo[6:0], 1'b0};
            t2      = {cur.r2, cur.n2lo[7]};
            ge2     = (t2 >= {1'b0, half_span_reg});
            nx.r2   = ge2 ? 7'(t2 - {1'b0, half_span_reg}) : t2[6:0];
            nx.q2   = {cur.q2[6:0], ge2};
            nx.n2lo = {cur.n2lo[6:0], 1'b0};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d2_reg[k] <= '0;
            end
            else
            begin
                d2_reg[k] <= nx;
            end
        end
    end

    p2_t p2_reg;
    p3_t p3_reg;
    p4_t p4_reg;

    logic        done_reg;
    logic        in_span_reg;
    logic [9:0]  led_index_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        mid_t        m;
        logic [7:0]  h;
        logic [23:0] col;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        if (!rst_n)
        begin
            p2_reg        <= '0;
            p3_reg        <= '0;
            p4_reg        <= '0;
            done_reg      <= 1'b0;
            in_span_reg   <= 1'b0;
            led_index_reg <= '0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
        end
        else
        begin
            m = d2_reg[QDIV_STEPS-1];
            h = 8'd255 - m.q1;
            p2_reg.valid    <= m.valid;
            p2_reg.hit      <= m.hit_on ? bspc_pkg::sc8(h, h) : 8'd0;
            p2_reg.falloff  <= 8'd255 - m.q2;
            p2_reg.strobe   <= m.strobe_on ? bspc_pkg::sc8(m.sval, strobe_level_reg) : 8'd0;
            p2_reg.in_range <= m.in_range;
            p2_reg.dim      <= m.dim;
            p2_reg.beat     <= m.beat;
            p2_reg.led      <= m.led;

            p3_reg.valid     <= p2_reg.valid;
            p3_reg.lit       <= bspc_pkg::sc8(p2_reg.falloff, p2_reg.hit);
            p3_reg.white     <= bspc_pkg::sc8(p2_reg.falloff, p2_reg.strobe);
            p3_reg.strobe_nz <= (p2_reg.strobe != 8'd0);
            p3_reg.in_range  <= p2_reg.in_range;
            p3_reg.dim       <= p2_reg.dim;
            p3_reg.beat      <= p2_reg.beat;
            p3_reg.led       <= p2_reg.led;

            p4_reg.valid     <= p3_reg.valid;
            p4_reg.level     <= bspc_pkg::sc8(p3_reg.lit,
                                   p3_reg.dim ? 8'(bspc_pkg::DIM_GAIN) : 8'd255);
            p4_reg.white     <= p3_reg.white;
            p4_reg.strobe_nz <= p3_reg.strobe_nz;
            p4_reg.in_range  <= p3_reg.in_range;
            p4_reg.beat      <= p3_reg.beat;
            p4_reg.led       <= p3_reg.led;

            col = bspc_pkg::palette(p4_reg.beat);
            r   = bspc_pkg::sc8(col[23:16], p4_reg.level);
            g   = bspc_pkg::sc8(col[15:8], p4_reg.level);
            b   = bspc_pkg::sc8(col[7:0], p4_reg.level);
            if (p4_reg.strobe_nz)
            begin
                r = (p4_reg.white > r) ? p4_reg.white : r;
                g = (p4_reg.white > g) ? p4_reg.white : g;
                b = (p4_reg.white > b) ? p4_reg.white : b;
            end
            done_reg      <= p4_reg.valid;
            in_span_reg   <= p4_reg.in_range;
            led_index_reg <= p4_reg.led;
            red_reg       <= p4_reg.in_range ? r : 8'd0;
            green_reg     <= p4_reg.in_range ? g : 8'd0;
            blue_reg      <= p4_reg.in_range ? b : 8'd0;
        end
    end

    assign done      = done_reg;
    assign in_span   = in_span_reg;
    assign led_index = led_index_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    `BSPC_ASSERT_NXT(a_cfg_busy, cfg_wr && !busy, busy, "register write did not raise busy")
    `BSPC_ASSERT_IMP(a_latency, accept, ##LATENCY done, "transfer result missing at latency")
    `BSPC_ASSERT_IMP(a_outside_black, done && !in_span, red == 8'd0 && green == 8'd0 && blue == 8'd0, "outside pixel not black")

endmodule
